FILE: rtl/core/pcm_pkg.sv
// ----------------------------------------------------------------------------
// Pointwise channel mixer package
// Shared sizes, item kinds, register indexes and the command word that the
// controller hands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pcm_pkg;

  localparam int MaxInChannels  = 16;
  localparam int MaxOutChannels = 16;
  localparam int IdxW           = 4;
  localparam int WeightAddrW    = 2 * IdxW;
  localparam int WeightDepth    = MaxInChannels * MaxOutChannels;
  localparam int DataW          = 16;
  localparam int ProdW          = 2 * DataW;
  localparam int AccW           = 40;
  localparam int SumW           = AccW + 1;
  localparam int FracShift      = 12;
  localparam int CountW         = 5;

  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_BIAS   = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  localparam logic CFG_ACTIVE_INPUTS  = 1'b0;
  localparam logic CFG_ACTIVE_OUTPUTS = 1'b1;

  typedef struct packed {
    logic            load_sample;
    logic            wr_weight;
    logic            wr_bias;
    logic            mac_issue;
    logic [IdxW-1:0] mac_idx;
    logic [IdxW-1:0] chan;
    logic            emit_issue;
    logic [IdxW-1:0] emit_idx;
    logic            emit_last;
    logic            clear_acc;
  } pcm_cmd_t;

  // Limits a channel count register to the range 1 .. 16.
  function automatic logic [CountW-1:0] clamp_count(input logic [CountW-1:0] v);
    logic [CountW-1:0] r;
    r = v;
    if (v == '0) begin
      r = CountW'(1);
    end else if (v > CountW'(MaxInChannels)) begin
      r = CountW'(MaxInChannels);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pcm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pcm_ctrl.sv
// ----------------------------------------------------------------------------
// Pointwise channel mixer controller
// Holds the channel count registers and the channel counter, and steps the
// datapath through the multiply-accumulate sweep and the result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [1:0]              kind,
  output      logic                    busy,
  input  wire logic                    cfg_valid,
  output      logic                    cfg_ready,
  input  wire logic                    cfg_index,
  input  wire logic [pcm_pkg::CountW-1:0] cfg_data,
  output      pcm_pkg::pcm_cmd_t       cmd
);
  import pcm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]        state, state_next;
  logic [IdxW-1:0]   idx, idx_next;
  logic [IdxW-1:0]   chan, chan_next;
  logic              drain_cnt, drain_cnt_next;
  logic [CountW-1:0] active_inputs, active_outputs;
  logic [CountW-1:0] nin, nout;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign nin       = clamp_count(active_inputs);
  assign nout      = clamp_count(active_outputs);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_inputs  <= CountW'(MaxInChannels);
      active_outputs <= CountW'(MaxOutChannels);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACTIVE_INPUTS:  active_inputs  <= cfg_data;
        CFG_ACTIVE_OUTPUTS: active_outputs <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    chan_next      = chan;
    drain_cnt_next = drain_cnt;
    cmd            = '0;
    cmd.chan       = chan;
    cmd.mac_idx    = idx;
    cmd.emit_idx   = idx;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_WEIGHT: cmd.wr_weight = 1'b1;
            KIND_BIAS:   cmd.wr_bias   = 1'b1;
            KIND_SAMPLE: begin
              cmd.load_sample = 1'b1;
              idx_next        = '0;
              state_next      = ST_MAC;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd.mac_issue = 1'b1;
        if (idx == IdxW'(MaxOutChannels - 1)) begin
          drain_cnt_next = 1'b0;
          state_next     = ST_DRAIN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_DRAIN: begin
        // The drain state lets the last product pass the weight read and product registers and reach its accumulator.
        if (drain_cnt) begin
          if (({1'b0, chan} + 1'b1) >= nin) begin
            chan_next  = '0;
            idx_next   = '0;
            state_next = ST_EMIT;
          end else begin
            chan_next  = chan + 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          drain_cnt_next = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.emit_issue = 1'b1;
        if (({1'b0, idx} + 1'b1) == nout) begin
          cmd.emit_last = 1'b1;
          cmd.clear_acc = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      chan      <= '0;
      drain_cnt <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      chan      <= chan_next;
      drain_cnt <= drain_cnt_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pcm_datapath.sv
// ----------------------------------------------------------------------------
// Pointwise channel mixer datapath
// Weight memory, bias registers, one shared multiplier feeding the
// accumulators, and the rounding and saturation stage for results.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pcm_pkg::pcm_cmd_t           cmd,
  input  wire logic [pcm_pkg::IdxW-1:0]    out_index,
  input  wire logic [pcm_pkg::IdxW-1:0]    in_index,
  input  wire logic signed [pcm_pkg::DataW-1:0] value,
  output      logic                        result_strobe,
  output      logic [pcm_pkg::IdxW-1:0]    out_channel,
  output      logic signed [pcm_pkg::DataW-1:0] result_value,
  output      logic                        last
);
  import pcm_pkg::*;

  localparam int QW = SumW - FracShift;

  logic signed [DataW-1:0] sample;
  logic [DataW-1:0]        weight_rd;
  logic                    rd_valid;
  logic [IdxW-1:0]         rd_idx;
  logic signed [ProdW-1:0] prod;
  logic                    prod_valid;
  logic [IdxW-1:0]         prod_idx;
  logic signed [AccW-1:0]  acc [MaxOutChannels];
  logic [DataW-1:0]        bias_store [MaxOutChannels];
  logic [IdxW-1:0]         acc_sel;
  logic signed [AccW-1:0]  acc_rd;
  logic signed [SumW-1:0]  sum_comb, sum;
  logic                    sum_valid, sum_last;
  logic [IdxW-1:0]         sum_idx;
  logic signed [QW-1:0]    q;
  logic [DataW-1:0]        sat;

  pcm_ram #(
    .Width(DataW),
    .Depth(WeightDepth)
  ) u_weight_ram (
    .clk  (clk),
    .we   (cmd.wr_weight),
    .waddr({out_index, in_index}),
    .wdata(value),
    .re   (cmd.mac_issue),
    .raddr({cmd.mac_idx, cmd.chan}),
    .rdata(weight_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample <= value;
    end
    if (cmd.wr_bias) begin
      bias_store[out_index] <= value;
    end
    if (rd_valid) begin
      prod     <= sample * $signed(weight_rd);
      prod_idx <= rd_idx;
    end
    rd_idx <= cmd.mac_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= cmd.mac_issue;
      prod_valid <= rd_valid;
    end
  end

  // Accumulation and emission never overlap, so one read port serves both.
  assign acc_sel = prod_valid ? prod_idx : cmd.emit_idx;
  assign acc_rd  = acc[acc_sel];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_acc) begin
      for (int i = 0; i < MaxOutChannels; i++) begin
        acc[i] <= '0;
      end
    end else if (prod_valid) begin
      acc[prod_idx] <= acc_rd + AccW'(prod);
    end
  end

  // Bias is aligned to the product scale, then half an LSB is added so the
  // arithmetic shift rounds half up.
  assign sum_comb = SumW'(acc_rd)
                  + {{(SumW - DataW - FracShift){bias_store[cmd.emit_idx][DataW-1]}},
                     bias_store[cmd.emit_idx], {FracShift{1'b0}}}
                  + SumW'(1 << (FracShift - 1));

  always_ff @(posedge clk) begin
    if (cmd.emit_issue) begin
      sum      <= sum_comb;
      sum_idx  <= cmd.emit_idx;
      sum_last <= cmd.emit_last;
    end
  end

  assign q = sum[SumW-1:FracShift];

  always_comb begin
    if (q[QW-1:DataW-1] == '0 || q[QW-1:DataW-1] == '1) begin
      sat = q[DataW-1:0];
    end else if (q[QW-1]) begin
      sat = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DataW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid     <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      sum_valid     <= cmd.emit_issue;
      result_strobe <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid) begin
      out_channel  <= sum_idx;
      result_value <= sat;
      last         <= sum_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pointwise_channel_mixer.sv
// ----------------------------------------------------------------------------
// Pointwise channel mixer
// A 1x1 convolution over 16 input and 16 output channels in fixed point.
// ----------------------------------------------------------------------------
// Weight and bias words are stored when accepted. A sample word is accepted,
// then the shared multiplier visits every output channel (one weight memory
// read per cycle) and the pipeline drains. The last sample of a pixel then
// issues an emission for each active output channel; each result passes the
// sum and output registers, and results come one per cycle. Results cannot
// be stalled. Reset clears the accumulators and channel counter and sets the
// count registers to 16; weights and biases are undefined until written.
`default_nettype none

module pointwise_channel_mixer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [1:0]                  kind,
  input  wire logic [pcm_pkg::IdxW-1:0]    out_index,
  input  wire logic [pcm_pkg::IdxW-1:0]    in_index,
  input  wire logic signed [pcm_pkg::DataW-1:0] value,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [pcm_pkg::CountW-1:0]  cfg_data,
  output      logic                        result_strobe,
  output      logic [pcm_pkg::IdxW-1:0]    out_channel,
  output      logic signed [pcm_pkg::DataW-1:0] result_value,
  output      logic                        last
);
  import pcm_pkg::*;

  pcm_cmd_t cmd;

  pcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .kind     (kind),
    .busy     (busy),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd)
  );

  pcm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .out_index    (out_index),
    .in_index     (in_index),
    .value        (value),
    .result_strobe(result_strobe),
    .out_channel  (out_channel),
    .result_value (result_value),
    .last         (last)
  );

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Pointwise channel mixer testbench
// Loads every weight and bias, then runs directed words at the numeric
// extremes and random traffic under several idle patterns. Each accepted word
// is fed to a local model of the mixer, and every result word is checked
// against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcm_pkg::*;

  localparam logic [1:0] KindIgnored = 2'd3;
  localparam int SettleCycles = 48;

  typedef struct {
    logic [IdxW-1:0]         chan;
    logic signed [DataW-1:0] val;
    logic                    last;
  } mix_result_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind = KIND_WEIGHT;
  logic [IdxW-1:0] out_index = '0;
  logic [IdxW-1:0] in_index = '0;
  logic signed [DataW-1:0] value = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_ACTIVE_INPUTS;
  logic [CountW-1:0] cfg_data = '0;
  logic result_strobe;
  logic [IdxW-1:0] out_channel;
  logic signed [DataW-1:0] result_value;
  logic last;

  pointwise_channel_mixer dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .out_index(out_index), .in_index(in_index), .value(value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_strobe(result_strobe), .out_channel(out_channel),
    .result_value(result_value), .last(last)
  );

  // Local copy of the mixer state.
  logic signed [DataW-1:0] weight_mem [MaxOutChannels][MaxInChannels];
  logic signed [DataW-1:0] bias_mem [MaxOutChannels];
  longint                  acc_mem [MaxOutChannels];
  int                      chan_cnt = 0;
  logic [CountW-1:0]       cfg_inputs = 5'd16;
  logic [CountW-1:0]       cfg_outputs = 5'd16;

  mix_result_t expected_results[$];
  int idle_pct = 0;
  int errors = 0;
  int words_sent = 0;
  int pixels_done = 0;
  int results_checked = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int eff_count(logic [CountW-1:0] v);
    if (v == '0) return 1;
    if (v > 5'd16) return 16;
    return int'(v);
  endfunction

  // Adds the Q8.8 bias at Q12.20, rounds half up to Q8.8 and saturates.
  function automatic logic signed [DataW-1:0] round_sat(longint acc,
                                                        logic signed [DataW-1:0] b);
    longint sum;
    longint q;
    sum = acc + longint'(b) * 4096 + 2048;
    q = sum >>> 12;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[DataW-1:0];
  endfunction

  function automatic void mix_word(logic [1:0] k, logic [IdxW-1:0] oi,
                                   logic [IdxW-1:0] ii, logic signed [DataW-1:0] v);
    int c;
    int nout;
    mix_result_t r;
    case (k)
      KIND_WEIGHT: weight_mem[oi][ii] = v;
      KIND_BIAS:   bias_mem[oi] = v;
      KIND_SAMPLE: begin
        c = chan_cnt;
        for (int o = 0; o < MaxOutChannels; o++) begin
          acc_mem[o] += longint'(v) * longint'(weight_mem[o][c]);
        end
        if (c + 1 < eff_count(cfg_inputs)) begin
          chan_cnt = c + 1;
        end else begin
          nout = eff_count(cfg_outputs);
          for (int o = 0; o < nout; o++) begin
            r.chan = o[IdxW-1:0];
            r.val  = round_sat(acc_mem[o], bias_mem[o]);
            r.last = (o == nout - 1);
            expected_results.push_back(r);
          end
          foreach (acc_mem[o]) acc_mem[o] = 0;
          chan_cnt = 0;
          pixels_done++;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    mix_result_t want;
    if (!rst && result_strobe) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: out_channel %0d result_value %0d",
               out_channel, result_value);
        errors++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_channel !== want.chan) begin
          $error("out_channel: expected %0d, got %0d", want.chan, out_channel);
          errors++;
        end
        if (result_value !== want.val) begin
          $error("result_value: expected %0d, got %0d", want.val, result_value);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          errors++;
        end
      end
    end
  end

  // Called just after a rising edge. Leaves start high when no gap follows.
  task automatic send_word(input logic [1:0] k, input logic [IdxW-1:0] oi,
                           input logic [IdxW-1:0] ii, input logic signed [DataW-1:0] v);
    start     <= 1'b1;
    kind      <= k;
    out_index <= oi;
    in_index  <= ii;
    value     <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    mix_word(k, oi, ii, v);
    words_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  // Holds the sender off until every expected word is in and the block is quiet.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (busy || expected_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_counts(input logic [CountW-1:0] nin, input logic [CountW-1:0] nout);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ACTIVE_INPUTS;
    cfg_data  <= nin;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_inputs = nin;
    cfg_index <= CFG_ACTIVE_OUTPUTS;
    cfg_data  <= nout;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_outputs = nout;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [DataW-1:0] rand_value();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return DataW'($urandom_range(511)) - 16'sd256;
      default: return DataW'($urandom);
    endcase
  endfunction

  // Mostly legal counts, now and then zero or a value beyond the channel limit.
  function automatic logic [CountW-1:0] rand_count();
    if ($urandom_range(7) == 0) begin
      return $urandom_range(1) ? 5'd0 : CountW'($urandom_range(17, 31));
    end
    return CountW'($urandom_range(1, 16));
  endfunction

  // Every entry is written before any sample can read it.
  task automatic test_load_stores();
    for (int o = 0; o < MaxOutChannels; o++) begin
      for (int i = 0; i < MaxInChannels; i++) begin
        send_word(KIND_WEIGHT, o[IdxW-1:0], i[IdxW-1:0], rand_value());
      end
      send_word(KIND_BIAS, o[IdxW-1:0], IdxW'($urandom), rand_value());
    end
  endtask

  // One-channel pixels so that each sample gives a full set of outputs, then out-of-range counts that clamp.
  task automatic test_extremes();
    set_counts(5'd1, 5'd16);
    send_word(KIND_WEIGHT, 4'd0, 4'd0, 16'sh8000);
    send_word(KIND_WEIGHT, 4'd1, 4'd0, 16'sh7fff);
    send_word(KIND_WEIGHT, 4'd2, 4'd0, 16'sd2048);
    send_word(KIND_WEIGHT, 4'd3, 4'd0, -16'sd2048);
    send_word(KIND_WEIGHT, 4'd4, 4'd0, 16'sd0);
    send_word(KIND_BIAS, 4'd0, 4'd15, 16'sh7fff);
    send_word(KIND_BIAS, 4'd1, 4'd15, 16'sh8000);
    send_word(KIND_BIAS, 4'd2, 4'd0, 16'sd0);
    send_word(KIND_BIAS, 4'd3, 4'd0, 16'sd0);
    send_word(KindIgnored, 4'd15, 4'd15, 16'sh7fff);
    send_word(KIND_SAMPLE, 4'd15, 4'd15, 16'sh8000);
    send_word(KIND_SAMPLE, 4'd0, 4'd0, 16'sh7fff);
    // Exactly half an LSB either side of zero exercises the round-half-up rule.
    send_word(KIND_SAMPLE, 4'd0, 4'd0, 16'sd1);
    send_word(KIND_SAMPLE, 4'd0, 4'd0, -16'sd1);
    send_word(KindIgnored, 4'd0, 4'd0, 16'sh8000);
    send_word(KIND_SAMPLE, 4'd0, 4'd0, 16'sd0);
    set_counts(5'd31, 5'd0);
    send_word(KIND_SAMPLE, 4'd7, 4'd9, rand_value());
    send_word(KIND_SAMPLE, 4'd8, 4'd6, rand_value());
  endtask

  // Shrinking the input count mid-pixel ends the pixel at the next sample.
  task automatic test_counter_past_end();
    set_counts(5'd16, 5'd1);
    repeat (5) send_word(KIND_SAMPLE, 4'd0, 4'd0, rand_value());
    set_counts(5'd3, 5'd16);
    send_word(KIND_SAMPLE, 4'd0, 4'd0, rand_value());
  endtask

  task automatic test_random_traffic(input int pct, input int words);
    int pick;
    idle_pct = pct;
    set_counts(rand_count(), rand_count());
    for (int n = 0; n < words; n++) begin
      if (n == words / 2) set_counts(rand_count(), rand_count());
      pick = $urandom_range(99);
      if (pick < 60)      send_word(KIND_SAMPLE, IdxW'($urandom), IdxW'($urandom),
                                    rand_value());
      else if (pick < 85) send_word(KIND_WEIGHT, IdxW'($urandom), IdxW'($urandom),
                                    rand_value());
      else if (pick < 95) send_word(KIND_BIAS, IdxW'($urandom), IdxW'($urandom),
                                    rand_value());
      else                send_word(KindIgnored, IdxW'($urandom), IdxW'($urandom),
                                    rand_value());
    end
  endtask

  initial begin
    foreach (acc_mem[o]) acc_mem[o] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_stores();
    test_extremes();
    test_counter_past_end();
    test_random_traffic(0, 45);
    test_random_traffic(85, 45);
    test_random_traffic(0, 45);
    test_random_traffic(20, 45);
    settle();
    if (expected_results.size() != 0) begin
      $error("%0d expected result words never arrived", expected_results.size());
      errors++;
    end
    $display("Sent %0d words over %0d pixels; %0d result words checked.",
             words_sent, pixels_done, results_checked);
    $display("Covered numeric extremes, count clamping, mid-pixel count changes and idling.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pcm_pkg.sv
rtl/core/pcm_ram.sv
rtl/core/pcm_ctrl.sv
rtl/core/pcm_datapath.sv
rtl/core/pointwise_channel_mixer.sv
verif/tb.sv
